FILE: hw/rtl/dbs_pkg.sv
// Shared constants, codes and types for the depth background subtract block.
// No dependencies; imported by dbs_bg_ram and depth_background_subtract.
package dbs_pkg;

  // Frame geometry and field widths
  localparam int NUM_PIXELS = 307200;
  localparam int IDX_W      = 19;
  localparam int DEPTH_W    = 8;
  localparam int MARGIN_W   = 9;
  localparam int MODE_W     = 2;
  localparam int ADDR_W     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int CMP_W      = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 2;
  // signed width for depth vs background + margin
  localparam int SUM_W      = DEPTH_W + 3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 2'd3;

  // Operating modes (unused code behaves as window only)
  localparam logic [MODE_W-1:0] MODE_WINDOW    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CALIBRATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RECOGNIZE = 2'd2;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Reset values of configuration registers
  localparam logic [DEPTH_W-1:0]  NEAR_RESET   = 8'd255;
  localparam logic [DEPTH_W-1:0]  FAR_RESET    = 8'd0;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 9'sd5;

  // Control state: clearing sweep or normal operation
  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

endpackage

FILE: hw/rtl/dbs_bg_ram.sv
// Background store: single write port, single read port, registered read.
// Depends on dbs_pkg for depth and address widths.
module dbs_bg_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [dbs_pkg::ADDR_W-1:0]  waddr,
  input  logic [dbs_pkg::DEPTH_W-1:0] wdata,
  input  logic                        re,
  input  logic [dbs_pkg::ADDR_W-1:0]  raddr,
  output logic [dbs_pkg::DEPTH_W-1:0] rdata
);
  import dbs_pkg::*;

  logic [DEPTH_W-1:0] mem [NUM_PIXELS];
  logic [DEPTH_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/depth_background_subtract.sv
// Depth background subtraction: near/far window, min-depth background store,
// foreground test. Depends on dbs_pkg and dbs_bg_ram.
// An accepted item passes stage 1 and the output register to out_valid; one
// pixel item per cycle while out_ready is high. The store read is registered;
// a write-back to the entry read in the same cycle is forwarded. A clear item
// walks all NUM_PIXELS (307200) entries one a cycle; in_ready stays low meanwhile.
// Reset: synchronous, active low; starts the same clearing walk of the store.
module depth_background_subtract (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [dbs_pkg::IDX_W-1:0]     in_pixel_index,
  input  logic [dbs_pkg::DEPTH_W-1:0]   in_depth,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dbs_pkg::DEPTH_W-1:0]   out_windowed_depth,
  output logic [dbs_pkg::DEPTH_W-1:0]   out_foreground_depth,
  output logic [dbs_pkg::DEPTH_W-1:0]   out_background_depth,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbs_pkg::MARGIN_W-1:0]  cfg_data
);
  import dbs_pkg::*;

  // configuration registers
  logic [DEPTH_W-1:0]  near_r;
  logic [DEPTH_W-1:0]  far_r;
  logic [MODE_W-1:0]   mode_r;
  logic [MARGIN_W-1:0] margin_r;

  // control
  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;

  // stage 1: item waiting for store data
  logic               s1_valid_r;
  logic               s1_kind_r;
  logic               s1_in_range_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [DEPTH_W-1:0] s1_depth_r;
  logic               fwd_hit_r;
  logic [DEPTH_W-1:0] fwd_data_r;

  // output register
  logic               out_valid_r;
  logic [DEPTH_W-1:0] out_win_r;
  logic [DEPTH_W-1:0] out_fg_r;
  logic [DEPTH_W-1:0] out_bg_r;

  // handshake and datapath nets
  logic               in_acc;
  logic               s1_adv;
  logic               in_range;
  logic [ADDR_W-1:0]  in_addr;
  logic [DEPTH_W-1:0] rd_data;
  logic [DEPTH_W-1:0] win_depth;
  logic [DEPTH_W-1:0] bg_old;
  logic [DEPTH_W-1:0] bg_new;
  logic [DEPTH_W-1:0] fg_depth;
  logic               upd_take;
  logic signed [SUM_W-1:0] bg_plus_margin;
  logic signed [SUM_W-1:0] depth_s;
  logic               px_we;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [DEPTH_W-1:0] ram_wdata;

  // handshakes
  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == ST_RUN) && (!s1_valid_r || s1_adv);
  assign in_acc    = in_valid && in_ready;

  assign in_range = (CMP_W'(in_pixel_index) < CMP_W'(NUM_PIXELS));
  assign in_addr  = ADDR_W'(in_pixel_index);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r   <= NEAR_RESET;
      far_r    <= FAR_RESET;
      mode_r   <= MODE_WINDOW;
      margin_r <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NEAR_LIMIT: near_r   <= cfg_data[DEPTH_W-1:0];
        CFG_FAR_LIMIT:  far_r    <= cfg_data[DEPTH_W-1:0];
        CFG_MODE:       mode_r   <= cfg_data[MODE_W-1:0];
        CFG_MARGIN:     margin_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // clearing walk control
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(NUM_PIXELS - 1)) begin
          state_nxt   = ST_RUN;
          clr_cnt_nxt = '0;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_RUN: begin
        if (in_acc && (in_kind == KIND_CLEAR)) begin
          state_nxt   = ST_CLEAR;
          clr_cnt_nxt = '0;
        end
      end
      default: begin
        state_nxt   = ST_CLEAR;
        clr_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // stage 1 datapath: window, read-modify-write of the background entry
  always_comb begin
    if ((s1_depth_r > near_r) || (s1_depth_r < far_r)) begin
      win_depth = '0;
    end else begin
      win_depth = s1_depth_r;
    end

    if (!s1_in_range_r) begin
      bg_old = '0;
    end else if (fwd_hit_r) begin
      bg_old = fwd_data_r;
    end else begin
      bg_old = rd_data;
    end

    upd_take = (bg_old == '0) || ((win_depth != '0) && (win_depth < bg_old));
    bg_new   = bg_old;
    fg_depth = win_depth;
    px_we    = 1'b0;

    depth_s        = SUM_W'($signed({1'b0, win_depth}));
    bg_plus_margin = SUM_W'($signed({1'b0, bg_old})) + SUM_W'($signed(margin_r));

    case (mode_r)
      MODE_CALIBRATE: begin
        if (s1_in_range_r) begin
          px_we = 1'b1;
          if (upd_take) begin
            bg_new = win_depth;
          end
        end
      end
      MODE_RECOGNIZE: begin
        if (depth_s < bg_plus_margin) begin
          fg_depth = '0;
        end
      end
      default: ;
    endcase
  end

  // store write port: clearing walk or pixel write-back
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv && (s1_kind_r == KIND_PIXEL) && px_we;
      ram_waddr = s1_addr_r;
      ram_wdata = bg_new;
    end
  end

  dbs_bg_ram u_bg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  // stage 1 registers; catch a write-back that lands while the same entry is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r     <= in_kind;
      s1_in_range_r <= in_range;
      s1_addr_r     <= in_addr;
      s1_depth_r    <= in_depth;
      fwd_hit_r     <= ram_we && (ram_waddr == in_addr);
      fwd_data_r    <= ram_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_kind_r == KIND_CLEAR) begin
        out_win_r <= '0;
        out_fg_r  <= '0;
        out_bg_r  <= '0;
      end else begin
        out_win_r <= win_depth;
        out_fg_r  <= fg_depth;
        out_bg_r  <= bg_new;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_windowed_depth   = out_win_r;
  assign out_foreground_depth = out_fg_r;
  assign out_background_depth = out_bg_r;

endmodule
